// File: hdl/ssg_pkg.sv
// Shared types and constants for the spiral scan coordinate generator.
package ssg_pkg;

    // Fixed field widths.
    localparam int COORD_W   = 7;
    localparam int GRID_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd1;

    // Request operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // Walk headings, turning clockwise.
    localparam logic [1:0] HEAD_EAST  = 2'd0;
    localparam logic [1:0] HEAD_SOUTH = 2'd1;
    localparam logic [1:0] HEAD_WEST  = 2'd2;
    localparam logic [1:0] HEAD_NORTH = 2'd3;

    // Input request payload.
    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
    } t_in_req;

    // Result payload.
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               valid_res;
        logic               last;
        logic               error;
    } t_out_res;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic clear;
        logic step;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;
        logic hit;
    } t_status;

endpackage

// File: hdl/spiral_scan_coordinate_generator.sv
// Top level of the spiral scan coordinate generator.
// Walks an outward clockwise spiral over a rows x cols grid, first heading east.
// Input channel (i_in_valid / o_in_ready / i_in_data): a start request loads the
// start cell and the current grid size and returns that cell; a next request
// walks the spiral, also off the grid, to the next in-grid cell and returns it.
// Output channel (o_out_valid / i_out_ready / o_out_data): one result per request,
// with last set on the final cell, valid_res clear after completion and error set
// for a start cell outside the grid.
// Configuration: i_cfg_we writes i_cfg_data to grid_rows (index 0) or grid_cols
// (index 1); a new size takes effect at the next start.
// Sequencing: a start request, or a next request after completion, goes from the
// idle state to the emit state; a next request that walks passes through the walk
// state, where the walk unit makes one step per cycle up to the next in-grid cell.
// Requests are handled one at a time; a new request is accepted while the
// previous result still waits in the output register. When the receiver stalls,
// the next result waits in the datapath and the block stops taking requests.
// Reset empties the output, sets the grid to 1 x 1 and leaves the spiral inactive.
module spiral_scan_coordinate_generator
    import ssg_pkg::*;
#(
    parameter int MAX_DIM = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_req              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_res             o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GRID_W-1:0]    i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // Sequencing and handshakes.
    ssg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in_data.operation),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Walk state, grid size and result registers.
    ssg_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_res       (o_out_data)
    );

endmodule

// File: hdl/ssg_dp.sv
// Datapath of the spiral scan generator: grid registers, walk state and result registers.
module ssg_dp
    import ssg_pkg::*;
#(
    parameter int MAX_DIM = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GRID_W-1:0]    i_cfg_data,
    input  t_in_req              i_req,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output t_out_res             o_res
);

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int CW  = DW + 3;
    localparam int LW  = DW + 2;
    localparam int CNW = 2 * DW;

    logic [GRID_W-1:0]    r_grid_rows;
    logic [GRID_W-1:0]    r_grid_cols;
    logic [DW-1:0]        r_lat_rows;
    logic [DW-1:0]        r_lat_cols;
    logic [CNW-1:0]       r_area;
    logic signed [CW-1:0] r_walk_row;
    logic signed [CW-1:0] r_walk_col;
    logic [1:0]           r_heading;
    logic [LW-1:0]        r_leg;
    logic [LW-1:0]        r_steps;
    logic [CNW-1:0]       r_cells;
    logic                 r_active;
    t_out_res             r_res;
    t_out_res             r_out;

    logic [DW-1:0]        clamp_rows;
    logic [DW-1:0]        clamp_cols;
    logic                 start_inside;
    logic                 start_single;
    logic signed [CW-1:0] n_row;
    logic signed [CW-1:0] n_col;
    logic [LW-1:0]        steps_inc;
    logic                 leg_end;
    logic [1:0]           n_heading;
    logic                 n_hit;
    logic [CNW-1:0]       cells_inc;
    logic                 walk_done;

    // Saturate a grid size at the largest supported dimension.
    function automatic logic [DW-1:0] clamp_dim(input logic [GRID_W-1:0] v);
        if (32'(v) > MAX_DIM) begin
            clamp_dim = DW'(MAX_DIM);
        end else begin
            clamp_dim = DW'(v);
        end
    endfunction

    // Take the low bits of a non-negative walk coordinate.
    function automatic logic [COORD_W-1:0] to_coord(input logic signed [CW-1:0] x);
        logic [31:0] w;
        w = 32'(x);
        to_coord = w[COORD_W-1:0];
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= GRID_W'(1);
            r_grid_cols <= GRID_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                CFG_GRID_COLS: r_grid_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Start cell check against the current grid size.
    always_comb begin
        clamp_rows   = clamp_dim(r_grid_rows);
        clamp_cols   = clamp_dim(r_grid_cols);
        start_inside = (32'(i_req.start_row) < 32'(clamp_rows))
                    && (32'(i_req.start_col) < 32'(clamp_cols));
        start_single = (clamp_rows == DW'(1)) && (clamp_cols == DW'(1));
    end

    // One spiral step and the in-grid test of the cell it reaches.
    always_comb begin
        n_row = r_walk_row;
        n_col = r_walk_col;
        case (r_heading)
            HEAD_EAST:  n_col = r_walk_col + CW'(1);
            HEAD_SOUTH: n_row = r_walk_row + CW'(1);
            HEAD_WEST:  n_col = r_walk_col - CW'(1);
            HEAD_NORTH: n_row = r_walk_row - CW'(1);
            default:    n_row = r_walk_row;
        endcase
        steps_inc = r_steps + LW'(1);
        leg_end   = (steps_inc >= r_leg);
        n_heading = r_heading + 2'd1;
        n_hit     = !n_row[CW-1] && !n_col[CW-1]
                 && (n_row[CW-2:0] < (CW-1)'(r_lat_rows))
                 && (n_col[CW-2:0] < (CW-1)'(r_lat_cols));
        cells_inc = r_cells + CNW'(1);
        walk_done = (cells_inc >= r_area);
    end

    // Spiral control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_row <= '0;
            r_walk_col <= '0;
            r_heading  <= HEAD_EAST;
            r_leg      <= LW'(1);
            r_steps    <= '0;
            r_cells    <= '0;
            r_active   <= 1'b0;
            r_lat_rows <= DW'(1);
            r_lat_cols <= DW'(1);
            r_area     <= CNW'(1);
        end else if (i_cmd.start) begin
            r_lat_rows <= clamp_rows;
            r_lat_cols <= clamp_cols;
            r_area     <= CNW'(clamp_rows) * CNW'(clamp_cols);
            r_walk_row <= CW'($signed({1'b0, i_req.start_row}));
            r_walk_col <= CW'($signed({1'b0, i_req.start_col}));
            r_heading  <= HEAD_EAST;
            r_leg      <= LW'(1);
            r_steps    <= '0;
            r_cells    <= start_inside ? CNW'(1) : '0;
            r_active   <= start_inside && !start_single;
        end else if (i_cmd.step) begin
            r_walk_row <= n_row;
            r_walk_col <= n_col;
            if (leg_end) begin
                r_steps   <= '0;
                r_heading <= n_heading;
                if (n_heading == HEAD_EAST || n_heading == HEAD_WEST) begin
                    r_leg <= r_leg + LW'(1);
                end
            end else begin
                r_steps <= steps_inc;
            end
            if (n_hit) begin
                r_cells  <= cells_inc;
                r_active <= !walk_done;
            end
        end
    end

    // Pending result, built while the output register may still be occupied.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_res.row       <= start_inside ? i_req.start_row : '0;
            r_res.col       <= start_inside ? i_req.start_col : '0;
            r_res.valid_res <= start_inside;
            r_res.last      <= start_inside && start_single;
            r_res.error     <= !start_inside;
        end else if (i_cmd.clear) begin
            r_res <= '0;
        end else if (i_cmd.step && n_hit) begin
            r_res.row       <= to_coord(n_row);
            r_res.col       <= to_coord(n_col);
            r_res.valid_res <= 1'b1;
            r_res.last      <= walk_done;
            r_res.error     <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_status.active = r_active;
    assign o_status.hit    = n_hit;
    assign o_res           = r_out;

`ifndef ASSERT_OFF
    a_hit_makes_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && n_hit) |=> (r_res.valid_res && !r_res.error))
        else $error("step onto a grid cell did not produce a valid result");

    a_error_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.start) |-> !(r_res.error && r_res.valid_res))
        else $error("start result flags both error and a cell");

    a_cells_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_cells < r_area))
        else $error("spiral active with every cell already emitted");
`endif

endmodule

// File: hdl/ssg_ctrl.sv
// Controller of the spiral scan generator: request handshake, walk sequencing, output valid.
module ssg_ctrl
    import ssg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_op,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_op == OP_START) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_EMIT;
                    end else if (i_status.active) begin
                        n_state = ST_WALK;
                    end else begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_EMIT;
                    end
                end
            end
            ST_WALK: begin
                o_cmd.step = 1'b1;
                if (i_status.hit) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && (!r_out_valid || i_out_ready)) |=> r_out_valid)
        else $error("result register loaded without raising valid");

    a_walk_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> i_status.active)
        else $error("walking while the spiral is inactive");

    a_idle_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && i_op == OP_NEXT && !i_status.active)
        |=> (r_state == ST_EMIT))
        else $error("next request after completion did not go to emit");
`endif

endmodule
